/* src/lcdint_pkg.sv */
// ============================================================================
// lcdint_pkg: shared types and constants
// Holds the mode codes, timing lengths, vector constants and the structs
// passed between the LCD sequencer, the dispatcher and the top level.
// ============================================================================
package lcdint_pkg;

    localparam int unsigned CyclesW  = 6;
    localparam int unsigned AccumW   = 10;
    localparam int unsigned LineW    = 8;
    localparam int unsigned SrcN     = 5;
    localparam int unsigned VectorW  = 7;

    localparam logic [AccumW-1:0] LenOam    = 10'd80;
    localparam logic [AccumW-1:0] LenXfer   = 10'd172;
    localparam logic [AccumW-1:0] LenHblank = 10'd204;
    localparam logic [AccumW-1:0] LenLine   = 10'd456;
    localparam logic [AccumW-1:0] AccumMax  = 10'd1023;

    localparam logic [LineW-1:0]  VblankLine = 8'd144;
    localparam logic [LineW-1:0]  LastLine   = 8'd153;

    localparam logic [VectorW-1:0] VecBase = 7'h40;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } lcd_mode_t;

    typedef struct packed {
        lcd_mode_t         mode;
        logic [AccumW-1:0] accum;
        logic [LineW-1:0]  line;
    } lcd_state_t;

    typedef struct packed {
        logic               valid;
        logic [VectorW-1:0] vector;
        logic [SrcN-1:0]    pending;
        logic               master;
    } disp_t;

endpackage

/* src/lcdint_sequencer.sv */
// ============================================================================
// lcdint_sequencer: LCD mode sequencer, next-state logic
// Adds the elapsed cycles to the accumulator and makes at most one mode
// transition per word, flagging the entry into vblank.
// ============================================================================
module lcdint_sequencer (
    input  lcdint_pkg::lcd_state_t              cur,
    input  logic [lcdint_pkg::CyclesW-1:0]      cycles,
    output lcdint_pkg::lcd_state_t              nxt,
    output logic                                vblank_entry
);
    import lcdint_pkg::*;

    logic [AccumW:0]   sum;
    logic [AccumW-1:0] acc;
    logic [LineW-1:0]  line_inc;

    always_comb begin
        sum      = {1'b0, cur.accum} + {{(AccumW+1-CyclesW){1'b0}}, cycles};
        acc      = sum[AccumW] ? AccumMax : sum[AccumW-1:0];
        line_inc = cur.line + 8'd1;

        nxt          = cur;
        nxt.accum    = acc;
        vblank_entry = 1'b0;

        case (cur.mode)
            MODE_HBLANK: begin
                if (acc >= LenHblank) begin
                    nxt.line  = line_inc;
                    nxt.accum = acc - LenHblank;
                    if (line_inc == VblankLine) begin
                        nxt.mode     = MODE_VBLANK;
                        vblank_entry = 1'b1;
                    end else begin
                        nxt.mode = MODE_OAM;
                    end
                end
            end
            MODE_VBLANK: begin
                if (acc >= LenLine) begin
                    nxt.accum = acc - LenLine;
                    if (line_inc > LastLine) begin
                        nxt.line = '0;
                        nxt.mode = MODE_OAM;
                    end else begin
                        nxt.line = line_inc;
                    end
                end
            end
            MODE_OAM: begin
                if (acc >= LenOam) begin
                    nxt.mode  = MODE_XFER;
                    nxt.accum = acc - LenOam;
                end
            end
            default: begin
                if (acc >= LenXfer) begin
                    nxt.mode  = MODE_HBLANK;
                    nxt.accum = acc - LenXfer;
                end
            end
        endcase
    end

endmodule

/* src/lcdint_dispatch.sv */
// ============================================================================
// lcdint_dispatch: vectored interrupt dispatcher
// Picks the lowest pending enabled source when the master enable is set,
// clears its flag and the master enable, and forms its handler vector.
// ============================================================================
module lcdint_dispatch (
    input  logic [lcdint_pkg::SrcN-1:0] pending,
    input  logic [lcdint_pkg::SrcN-1:0] enable,
    input  logic                        master,
    output lcdint_pkg::disp_t           result
);
    import lcdint_pkg::*;

    logic [SrcN-1:0] fire;
    logic [2:0]      src;

    always_comb begin
        fire = pending & enable;
        src  = 3'd0;
        // Scan from the top down so the lowest set bit wins.
        for (int k = SrcN - 1; k >= 0; k--) begin
            if (fire[k]) begin
                src = 3'(k);
            end
        end

        result.valid   = 1'b0;
        result.vector  = '0;
        result.pending = pending;
        result.master  = master;
        if (master && (fire != '0)) begin
            result.valid        = 1'b1;
            result.vector       = VecBase + {1'b0, src, 3'b000};
            result.pending[src] = 1'b0;
            result.master       = 1'b0;
        end
    end

endmodule

/* src/lcd_mode_timing_and_interrupt_dispatch.sv */
// ============================================================================
// lcd_mode_timing_and_interrupt_dispatch: LCD timing with vectored interrupts
// Top level: input register, LCD sequencer and dispatcher logic, block state
// and the result register.
// ============================================================================
//
//  Channel   Ports                         Direction  Moves per word
//  -------   ----------------------------  ---------  ----------------------
//  input     s_valid / s_ready / s_*       in         one emulated CPU step
//  result    m_valid / m_ready / m_*       out        one status result
//  config    cfg_wr_en / cfg_wr_data       in         enable mask write
//
//  A word is captured in the input register at its accepting edge and its
//  result is loaded into the result register when the step fires, which
//  waits while the result register is full and m_ready is low.
//  A new word can be accepted every cycle while the result channel does not stall;
//  the mode, accumulator, line and interrupt state are updated in one step per word.
//  When the result register is full and m_ready is low, the input register
//  holds its word and s_ready drops once it is occupied.
//  aresetn is synchronous and active low; it clears all control and block
//  state, including the enable mask.
//
module lcd_mode_timing_and_interrupt_dispatch (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [lcdint_pkg::CyclesW-1:0]     s_elapsed_cycles,
    input  logic [lcdint_pkg::SrcN-1:0]        s_request_bits,
    input  logic                               s_master_set,
    input  logic                               s_master_clear,

    input  logic                               cfg_wr_en,
    input  logic [lcdint_pkg::SrcN-1:0]        cfg_wr_data,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_lcd_mode,
    output logic [lcdint_pkg::LineW-1:0]       m_current_line,
    output logic                               m_dispatch_valid,
    output logic [lcdint_pkg::VectorW-1:0]     m_dispatch_vector,
    output logic [lcdint_pkg::SrcN-1:0]        m_pending_now
);
    import lcdint_pkg::*;

    // Input register. The word sits here while its step is computed.
    logic               in_vld_reg;
    logic [CyclesW-1:0] in_cycles_reg;
    logic [SrcN-1:0]    in_req_reg;
    logic               in_set_reg;
    logic               in_clr_reg;

    // Block state; LCD, pending and master state update once per processed word.
    lcd_state_t         lcd_reg, lcd_next;
    logic [SrcN-1:0]    pending_reg;
    logic               master_reg;
    logic [SrcN-1:0]    enable_reg;

    // Result register.
    logic               out_vld_reg;
    logic [1:0]         out_mode_reg;
    logic [LineW-1:0]   out_line_reg;
    logic               out_dvalid_reg;
    logic [VectorW-1:0] out_vector_reg;
    logic [SrcN-1:0]    out_pending_reg;

    logic               advance;
    logic               vblank_entry;
    logic               master_pre;
    logic [SrcN-1:0]    pending_pre;
    disp_t              disp;

    // The step fires when a word is held and the result register can take it.
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    lcdint_sequencer u_seq (
        .cur          (lcd_reg),
        .cycles       (in_cycles_reg),
        .nxt          (lcd_next),
        .vblank_entry (vblank_entry)
    );

    // Master-enable events come first (clear, then set), then the new
    // requests and a possible vblank request join the pending flags.
    always_comb begin
        master_pre  = in_set_reg ? 1'b1 : (in_clr_reg ? 1'b0 : master_reg);
        pending_pre = pending_reg | in_req_reg;
        if (vblank_entry && enable_reg[0]) begin
            pending_pre[0] = 1'b1;
        end
    end

    lcdint_dispatch u_disp (
        .pending (pending_pre),
        .enable  (enable_reg),
        .master  (master_pre),
        .result  (disp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            lcd_reg     <= '{mode: MODE_HBLANK, accum: '0, line: '0};
            pending_reg <= '0;
            master_reg  <= 1'b0;
            enable_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                enable_reg <= cfg_wr_data;
            end

            if (s_ready) begin
                in_vld_reg <= s_valid;
            end

            if (advance) begin
                lcd_reg     <= lcd_next;
                pending_reg <= disp.pending;
                master_reg  <= disp.master;
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_cycles_reg <= s_elapsed_cycles;
            in_req_reg    <= s_request_bits;
            in_set_reg    <= s_master_set;
            in_clr_reg    <= s_master_clear;
        end
        if (advance) begin
            out_mode_reg    <= lcd_next.mode;
            out_line_reg    <= lcd_next.line;
            out_dvalid_reg  <= disp.valid;
            out_vector_reg  <= disp.vector;
            out_pending_reg <= disp.pending;
        end
    end

    assign m_valid           = out_vld_reg;
    assign m_lcd_mode        = out_mode_reg;
    assign m_current_line    = out_line_reg;
    assign m_dispatch_valid  = out_dvalid_reg;
    assign m_dispatch_vector = out_vector_reg;
    assign m_pending_now     = out_pending_reg;

endmodule
